>>> src/rv64s_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rv64s_pkg
// types, constants and decode helpers shared by the rv64 instruction step core
// ---------------------------------------------------------------------------
package rv64s_pkg;

  localparam int unsigned MemBytesDefault = 262144;
  localparam int unsigned RegCount        = 32;
  localparam int unsigned PcW             = 18;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpImmW   = 7'h1b;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpRegW   = 7'h3b;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InstEcall = 32'h0000_0073;

  localparam logic [6:0] F7Zero = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;
  localparam logic [6:0] F7Mul  = 7'h01;
  localparam logic [5:0] F6Sra  = 6'h10;

  localparam logic [63:0] EcallExit = 64'd0;
  localparam logic [63:0] EcallGetc = 64'd1;
  localparam logic [63:0] EcallPutc = 64'd2;

  localparam logic [4:0] RegA0 = 5'd10;
  localparam logic [4:0] RegA7 = 5'd17;
  localparam logic [4:0] RegSp = 5'd2;

  typedef struct packed {
    logic        req_type;
    logic [15:0] load_word_index;
    logic [31:0] load_word_data;
    logic [7:0]  console_in;
  } in_item_t;

  typedef struct packed {
    logic [17:0]        pc_after;
    logic               rd_written;
    logic [4:0]         rd_index;
    logic signed [63:0] rd_value;
    logic               console_out_valid;
    logic [7:0]         console_out;
    logic               console_in_taken;
    logic               halted;
    logic               illegal;
  } out_item_t;

  // divider command and status
  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic        is_word;
    logic        want_rem;
    logic [63:0] a;
    logic [63:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } div_rsp_t;

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage
`default_nettype wire

>>> src/rv64_instruction_step_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rv64_instruction_step_top
// multicycle core for a subset of rv64im that preloads memory or steps one instruction
// ---------------------------------------------------------------------------
// One transaction at a time. A preload writes its four bytes through the one
// byte-wide memory port before it reaches the output register. An instruction
// goes through fetch (four byte reads), register reads, execute and writeback,
// plus a memory access per loaded or stored byte, the multiplier for a multiply
// (three 32x32 partial products on a shared multiplier) or the divider for a
// divide or remainder (one quotient bit per cycle). in_stall drops as the
// result enters the output register; if the previous result is still waiting
// there, the core holds until it is taken.
module rv64_instruction_step_top
  import rv64s_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PRE   = 14'b00000000000010,
    S_FETCH = 14'b00000000000100,
    S_RS1   = 14'b00000000001000,
    S_RS2   = 14'b00000000010000,
    S_A7    = 14'b00000000100000,
    S_EXEC  = 14'b00000001000000,
    S_MEM   = 14'b00000010000000,
    S_MUL   = 14'b00000100000000,
    S_DIV   = 14'b00001000000000,
    S_WB    = 14'b00010000000000,
    S_OUT   = 14'b00100000000000,
    S_MULW  = 14'b01000000000000,
    S_RDWT  = 14'b10000000000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  mrd_r;
  logic [63:0] rf [RegCount];
  logic [63:0] rfq_r;
  logic [AW-1:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  in_item_t    item_r;
  logic [31:0] inst_r, inst_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, x17_r, x17_nxt;
  logic [63:0] val_r, val_nxt;
  logic [AW-1:0] eaddr_r, eaddr_nxt, next_r, next_nxt;
  logic        wr_r, wr_nxt, bad_r, bad_nxt, cov_r, cov_nxt, cit_r, cit_nxt;
  logic [4:0]  rd_r, rd_nxt;
  out_item_t   out_r, out_nxt;
  logic        ov_r, ov_nxt;

  // memory port
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wd;
  // register file port
  logic          r_we;
  logic [4:0]    r_ra, r_wa;
  logic [63:0]   r_wd;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        mstart, mdone;
  logic [63:0] mres;

  rv64s_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  rv64s_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(a_r), .b(b_r),
                   .done(mdone), .result(mres));

  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    mrd_r <= mem[m_addr];
  end

  // x2 resets to the memory size; clear on reset goes through a sweep-free
  // flop array since the file is small
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++)
        rf[i] <= (i == int'(RegSp)) ? 64'(MEM_BYTES) : 64'd0;
    end else if (r_we && r_wa != 5'd0) begin
      rf[r_wa] <= r_wd;
    end
  end
  always_ff @(posedge clk) rfq_r <= rf[r_ra];

  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [63:0] immI, immS, immB, immJ, immU, addv;
  logic [5:0]  sh;
  logic [63:0] ra, rb;
  logic        take;
  logic [63:0] pcx;

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; halt_nxt = halt_r; inst_nxt = inst_r;
    bcnt_nxt = bcnt_r; a_nxt = a_r; b_nxt = b_r; x17_nxt = x17_r; val_nxt = val_r;
    eaddr_nxt = eaddr_r; next_nxt = next_r; wr_nxt = wr_r; bad_nxt = bad_r;
    cov_nxt = cov_r; cit_nxt = cit_r; rd_nxt = rd_r; out_nxt = out_r;
    ov_nxt = ov_r && out_stall;
    m_we = 1'b0; m_addr = '0; m_wd = 8'd0;
    r_we = 1'b0; r_wa = rd_r; r_wd = val_r; r_ra = 5'd0;
    mstart = 1'b0;
    dreq = '0; dreq.a = a_r; dreq.b = b_r;

    opc = inst_r[6:0]; f3 = inst_r[14:12]; f7 = inst_r[31:25];
    immI = {{52{inst_r[31]}}, inst_r[31:20]};
    immS = {{52{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
    immB = {{51{inst_r[31]}}, inst_r[31], inst_r[7], inst_r[30:25], inst_r[11:8], 1'b0};
    immJ = {{43{inst_r[31]}}, inst_r[31], inst_r[19:12], inst_r[20], inst_r[30:21], 1'b0};
    immU = sx32({32'd0, inst_r[31:12], 12'd0});
    pcx  = 64'(pc_r);
    ra = a_r; rb = b_r;
    sh = 6'd0; addv = 64'd0; take = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          bcnt_nxt = 4'd0;
          cov_nxt = 1'b0; cit_nxt = 1'b0; wr_nxt = 1'b0; bad_nxt = 1'b0;
          rd_nxt = 5'd0; val_nxt = 64'd0;
          if (!in_data.req_type) st_nxt = S_PRE;
          else if (halt_r) st_nxt = S_OUT;
          else begin
            st_nxt = S_FETCH;
            m_addr = pc_r;
          end
        end
      end
      S_PRE: begin
        m_we = 1'b1;
        m_addr = AW'({item_r.load_word_index, 2'b00} + 18'(bcnt_r));
        m_wd = item_r.load_word_data[8*bcnt_r[1:0] +: 8];
        bcnt_nxt = bcnt_r + 4'd1;
        if (bcnt_r == 4'd3) st_nxt = S_OUT;
      end
      S_FETCH: begin
        // byte bcnt is in mrd_r; issue the next one
        inst_nxt = {mrd_r, inst_r[31:8]};
        bcnt_nxt = bcnt_r + 4'd1;
        m_addr = pc_r + AW'(bcnt_r) + AW'(1);
        if (bcnt_r == 4'd3) begin
          st_nxt = S_RS1;
          r_ra = inst_nxt[19:15];
        end
      end
      S_RS1: begin
        a_nxt = rfq_r;
        r_ra = inst_r[24:20];
        st_nxt = S_RS2;
      end
      S_RS2: begin
        b_nxt = rfq_r;
        r_ra = RegA7;
        st_nxt = S_A7;
      end
      S_A7: begin
        x17_nxt = rfq_r;
        r_ra = RegA0;
        st_nxt = S_RDWT;
      end
      S_RDWT: begin
        // keep a0 on the read port so it is in rfq_r during execute
        r_ra = RegA0;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        next_nxt = pc_r + AW'(4);
        rd_nxt = inst_r[11:7];
        st_nxt = S_WB;
        bcnt_nxt = 4'd0;
        if (opc[1:0] != 2'b11) bad_nxt = 1'b1;
        else begin
          unique case (opc)
            OpLui:   begin val_nxt = immU; wr_nxt = 1'b1; end
            OpAuipc: begin val_nxt = pcx + immU; wr_nxt = 1'b1; end
            OpJal:   begin val_nxt = pcx + 64'd4; wr_nxt = 1'b1;
                           next_nxt = AW'(pcx + immJ); end
            OpJalr: begin
              if (f3 != 3'd0) bad_nxt = 1'b1;
              else begin
                addv = ra + immI;
                next_nxt = AW'({addv[63:1], 1'b0});
                val_nxt = pcx + 64'd4; wr_nxt = 1'b1;
              end
            end
            OpBranch: begin
              unique case (f3)
                3'd0: take = ra == rb;
                3'd1: take = ra != rb;
                3'd4: take = $signed(ra) < $signed(rb);
                3'd5: take = $signed(ra) >= $signed(rb);
                default: bad_nxt = 1'b1;
              endcase
              if (take) next_nxt = AW'(pcx + immB);
            end
            OpLoad: begin
              if (f3 == 3'd7) bad_nxt = 1'b1;
              else begin
                addv = ra + immI;
                eaddr_nxt = AW'(addv);
                m_addr = AW'(addv);
                wr_nxt = 1'b1; val_nxt = 64'd0;
                st_nxt = S_MEM;
              end
            end
            OpStore: begin
              if (f3[2]) bad_nxt = 1'b1;
              else begin
                addv = ra + immS;
                eaddr_nxt = AW'(addv);
                st_nxt = S_MEM;
              end
            end
            OpImm: begin
              wr_nxt = 1'b1;
              sh = inst_r[25:20];
              case (f3)
                3'd0: val_nxt = ra + immI;
                3'd4: val_nxt = ra ^ immI;
                3'd6: val_nxt = ra | immI;
                3'd7: val_nxt = ra & immI;
                3'd1: if (inst_r[31:26] == 6'd0) val_nxt = ra << sh;
                      else bad_nxt = 1'b1;
                3'd5: if (inst_r[31:26] == 6'd0) val_nxt = ra >> sh;
                      else if (inst_r[31:26] == F6Sra) val_nxt = $signed(ra) >>> sh;
                      else bad_nxt = 1'b1;
                default: bad_nxt = 1'b1;
              endcase
            end
            OpImmW: begin
              wr_nxt = 1'b1;
              sh = {1'b0, inst_r[24:20]};
              if (f3 == 3'd0) val_nxt = sx32(ra + immI);
              else if (f3 == 3'd1 && f7 == F7Zero) val_nxt = sx32(ra << sh);
              else if (f3 == 3'd5 && f7 == F7Zero)
                val_nxt = sx32({32'd0, ra[31:0]} >> sh);
              else if (f3 == 3'd5 && f7 == F7Alt) val_nxt = sx32($signed(sx32(ra)) >>> sh);
              else bad_nxt = 1'b1;
            end
            OpReg: begin
              wr_nxt = 1'b1;
              sh = rb[5:0];
              if (f7 == F7Zero) begin
                case (f3)
                  3'd0: val_nxt = ra + rb;
                  3'd1: val_nxt = ra << sh;
                  3'd4: val_nxt = ra ^ rb;
                  3'd5: val_nxt = ra >> sh;
                  3'd6: val_nxt = ra | rb;
                  3'd7: val_nxt = ra & rb;
                  default: bad_nxt = 1'b1;
                endcase
              end else if (f7 == F7Alt && f3 == 3'd0) val_nxt = ra - rb;
              else if (f7 == F7Alt && f3 == 3'd5) val_nxt = $signed(ra) >>> sh;
              else if (f7 == F7Mul && f3 == 3'd0) begin
                mstart = 1'b1; st_nxt = S_MUL;
              end else if (f7 == F7Mul && (f3 == 3'd4 || f3 == 3'd6)) begin
                dreq.start = 1'b1; dreq.is_signed = 1'b1; dreq.want_rem = f3[1];
                st_nxt = S_DIV;
              end else bad_nxt = 1'b1;
            end
            OpRegW: begin
              wr_nxt = 1'b1;
              sh = {1'b0, rb[4:0]};
              if (f7 == F7Zero && f3 == 3'd0) val_nxt = sx32(ra + rb);
              else if (f7 == F7Alt && f3 == 3'd0) val_nxt = sx32(ra - rb);
              else if (f7 == F7Mul && f3 == 3'd0) begin
                mstart = 1'b1; st_nxt = S_MULW;
              end else if (f7 == F7Zero && f3 == 3'd1) val_nxt = sx32(ra << sh);
              else if (f7 == F7Zero && f3 == 3'd5)
                val_nxt = sx32({32'd0, ra[31:0]} >> sh);
              else if (f7 == F7Alt && f3 == 3'd5) val_nxt = sx32($signed(sx32(ra)) >>> sh);
              else if (f7 == F7Mul && f3[2]) begin
                dreq.start = 1'b1; dreq.is_word = 1'b1; dreq.is_signed = !f3[0];
                dreq.want_rem = f3[1];
                st_nxt = S_DIV;
              end else bad_nxt = 1'b1;
            end
            OpSystem: begin
              if (inst_r != InstEcall) bad_nxt = 1'b1;
              else if (x17_r == EcallExit) halt_nxt = 1'b1;
              else if (x17_r == EcallGetc) begin
                rd_nxt = RegA0; val_nxt = {56'd0, item_r.console_in};
                wr_nxt = 1'b1; cit_nxt = 1'b1;
              end else if (x17_r == EcallPutc) begin
                cov_nxt = 1'b1; val_nxt = rfq_r;
              end
            end
            default: bad_nxt = 1'b1;
          endcase
        end
        if (bad_nxt) begin
          st_nxt = S_WB; wr_nxt = 1'b0; next_nxt = pc_r + AW'(4);
        end
      end
      S_MEM: begin
        if (opc == OpLoad) begin
          // read data for byte bcnt arrives through mrd_r in the cycle after its address
          m_addr = eaddr_r + AW'(bcnt_r) + AW'(1);
          val_nxt[8*bcnt_r[2:0] +: 8] = mrd_r;
          bcnt_nxt = bcnt_r + 4'd1;
          if (bcnt_r == ((4'd1 << f3[1:0]) - 4'd1)) begin
            st_nxt = S_WB;
            case (f3)
              3'd0: val_nxt = {{56{mrd_r[7]}}, mrd_r};
              3'd1: val_nxt = {{48{mrd_r[7]}}, mrd_r, val_r[7:0]};
              3'd2: val_nxt = {{32{mrd_r[7]}}, mrd_r, val_r[23:0]};
              3'd4: val_nxt = {56'd0, mrd_r};
              3'd5: val_nxt = {48'd0, mrd_r, val_r[7:0]};
              3'd6: val_nxt = {32'd0, mrd_r, val_r[23:0]};
              default: val_nxt = {mrd_r, val_r[55:0]};
            endcase
          end
        end else begin
          m_we = 1'b1;
          m_addr = eaddr_r + AW'(bcnt_r);
          m_wd = rb[8*bcnt_r[2:0] +: 8];
          bcnt_nxt = bcnt_r + 4'd1;
          if (bcnt_r == ((4'd1 << f3[1:0]) - 4'd1)) st_nxt = S_WB;
        end
      end
      S_MUL: if (mdone) begin val_nxt = mres; st_nxt = S_WB; end
      S_MULW: if (mdone) begin val_nxt = sx32(mres); st_nxt = S_WB; end
      S_DIV: if (drsp.done) begin val_nxt = drsp.result; st_nxt = S_WB; end
      S_WB: begin
        r_we = wr_r;
        pc_nxt = next_r;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          out_nxt = '0;
          out_nxt.pc_after = PcW'(pc_r);
          out_nxt.halted = halt_r;
          out_nxt.illegal = bad_r;
          if (wr_r && rd_r != 5'd0) begin
            out_nxt.rd_written = 1'b1; out_nxt.rd_index = rd_r;
            out_nxt.rd_value = val_r;
          end
          out_nxt.console_out_valid = cov_r;
          out_nxt.console_out = cov_r ? val_r[7:0] : 8'd0;
          out_nxt.console_in_taken = cit_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      halt_r <= 1'b0;
      ov_r <= 1'b0;
      wr_r <= 1'b0; bad_r <= 1'b0; cov_r <= 1'b0; cit_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      halt_r <= halt_nxt;
      ov_r <= ov_nxt;
      wr_r <= wr_nxt; bad_r <= bad_nxt; cov_r <= cov_nxt; cit_r <= cit_nxt;
    end
    if (st_r == S_IDLE && in_valid) item_r <= in_data;
    inst_r <= inst_nxt; bcnt_r <= bcnt_nxt; a_r <= a_nxt; b_r <= b_nxt;
    x17_r <= x17_nxt; val_r <= val_nxt; eaddr_r <= eaddr_nxt; next_r <= next_nxt;
    rd_r <= rd_nxt; out_r <= out_nxt;
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall)
    else $error("input open while busy");
  a_rdw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rd_written |-> out_data.rd_index != 5'd0)
    else $error("x0 reported as written");

endmodule
`default_nettype wire

>>> src/rv64s_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rv64s_div
// radix-2 restoring divider, one quotient bit per cycle, signed and w forms
// ---------------------------------------------------------------------------
module rv64s_div
  import rv64s_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt;
  logic        zero_r, zero_nxt, word_r, word_nxt, wrem_r, wrem_nxt;
  logic [63:0] dvd0_r, dvd0_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;

  logic [63:0] a_in, b_in, ua, ub, qf, rf, rsel;
  logic [64:0] trial;
  logic        na, nb;

  always_comb begin
    a_in = req.is_word ? (req.is_signed ? sx32(req.a) : {32'd0, req.a[31:0]}) : req.a;
    b_in = req.is_word ? (req.is_signed ? sx32(req.b) : {32'd0, req.b[31:0]}) : req.b;
    na = req.is_signed & a_in[63];
    nb = req.is_signed & b_in[63];
    ua = na ? 64'd0 - a_in : a_in;
    ub = nb ? 64'd0 - b_in : b_in;

    busy_nxt = busy_r; cnt_nxt = cnt_r; quo_nxt = quo_r; rem_nxt = rem_r;
    dvs_nxt = dvs_r; negq_nxt = negq_r; negr_nxt = negr_r; zero_nxt = zero_r;
    word_nxt = word_r; wrem_nxt = wrem_r; dvd0_nxt = dvd0_r;
    done_nxt = 1'b0; res_nxt = res_r;
    trial = {rem_r, quo_r[63]} - {1'b0, dvs_r};
    qf = negq_r ? 64'd0 - quo_r : quo_r;
    rf = negr_r ? 64'd0 - rem_r : rem_r;
    rsel = 64'd0;

    if (req.start && !busy_r) begin
      busy_nxt = 1'b1; cnt_nxt = 7'd64; quo_nxt = ua; rem_nxt = 64'd0;
      dvs_nxt = ub; negq_nxt = na ^ nb; negr_nxt = na; zero_nxt = (b_in == 64'd0);
      word_nxt = req.is_word; wrem_nxt = req.want_rem; dvd0_nxt = a_in;
    end else if (busy_r) begin
      if (cnt_r != 7'd0) begin
        if (!trial[64]) begin
          rem_nxt = trial[63:0];
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[62:0], quo_r[63]};
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
      end else begin
        // divide by zero: all-ones quotient, dividend as remainder
        if (zero_r) rsel = wrem_r ? dvd0_r : '1;
        else        rsel = wrem_r ? rf : qf;
        res_nxt  = word_r ? sx32(rsel) : rsel;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
    negq_r <= negq_nxt; negr_r <= negr_nxt; zero_r <= zero_nxt;
    word_r <= word_nxt; wrem_r <= wrem_nxt; dvd0_r <= dvd0_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
`default_nettype wire

>>> src/rv64s_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rv64s_mul
// low 64 bits of a 64x64 product from three 32x32 partial products, one a cycle
// ---------------------------------------------------------------------------
module rv64s_mul
  import rv64s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result
);

  logic [2:0]  step_r, step_nxt;
  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [63:0] pp_r, pp_nxt;
  logic        done_r, done_nxt;
  logic [31:0] xa, xb;

  always_comb begin
    step_nxt = step_r; acc_nxt = acc_r; done_nxt = 1'b0;
    xa = a_r[31:0]; xb = b_r[31:0];
    case (step_r)
      3'd2: begin xa = a_r[63:32]; xb = b_r[31:0]; end
      3'd3: begin xa = a_r[31:0];  xb = b_r[63:32]; end
      default: ;
    endcase
    pp_nxt = 64'(xa) * 64'(xb);
    case (step_r)
      3'd0: if (start) begin step_nxt = 3'd1; acc_nxt = 64'd0; end
      3'd1: step_nxt = 3'd2;
      3'd2: begin acc_nxt = pp_r; step_nxt = 3'd3; end
      3'd3: begin acc_nxt = acc_r + {pp_r[31:0], 32'd0}; step_nxt = 3'd4; end
      3'd4: begin acc_nxt = acc_r + {pp_r[31:0], 32'd0}; step_nxt = 3'd0;
                  done_nxt = 1'b1; end
      default: step_nxt = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    if (start && step_r == 3'd0) begin
      a_r <= a;
      b_r <= b;
    end
    acc_r <= acc_nxt;
    pp_r  <= pp_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule
`default_nettype wire

>>> dv/rv64s_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rv64s_tb_pkg
// request kinds and funct3 codes shared by the rv64 step testbench files
// ---------------------------------------------------------------------------
package rv64s_tb_pkg;

  localparam logic ReqPreload = 1'b0;
  localparam logic ReqExec    = 1'b1;

  // branches
  localparam logic [2:0] F3Beq = 3'd0;
  localparam logic [2:0] F3Bne = 3'd1;
  localparam logic [2:0] F3Blt = 3'd4;
  localparam logic [2:0] F3Bge = 3'd5;

  // loads and stores
  localparam logic [2:0] F3Lb  = 3'd0;
  localparam logic [2:0] F3Lh  = 3'd1;
  localparam logic [2:0] F3Lw  = 3'd2;
  localparam logic [2:0] F3Ld  = 3'd3;
  localparam logic [2:0] F3Lbu = 3'd4;
  localparam logic [2:0] F3Lhu = 3'd5;
  localparam logic [2:0] F3Lwu = 3'd6;
  localparam logic [2:0] F3Sd  = 3'd3;

  // integer ops
  localparam logic [2:0] F3Add = 3'd0;
  localparam logic [2:0] F3Sll = 3'd1;
  localparam logic [2:0] F3Xor = 3'd4;
  localparam logic [2:0] F3Srl = 3'd5;
  localparam logic [2:0] F3Or  = 3'd6;
  localparam logic [2:0] F3And = 3'd7;

  // multiply and divide
  localparam logic [2:0] F3Mul  = 3'd0;
  localparam logic [2:0] F3Div  = 3'd4;
  localparam logic [2:0] F3Divu = 3'd5;
  localparam logic [2:0] F3Rem  = 3'd6;
  localparam logic [2:0] F3Remu = 3'd7;

endpackage

>>> dv/rv64_step_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rv64_step_checker
// watches both channels, predicts each result of the core and compares
// ---------------------------------------------------------------------------
module rv64_step_checker
  import rv64s_pkg::*;
  import rv64s_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  bit [7:0]     mem_img [0:MemBytesDefault-1];
  bit [63:0]    xreg [0:RegCount-1];
  bit [PcW-1:0] pc_q;
  bit           halt_q;
  out_item_t    result_q[$];
  int unsigned  errors;

  function automatic bit [63:0] get_bytes(bit [63:0] addr, int n);
    bit [63:0] v;
    bit [17:0] ix;
    v = '0;
    for (int i = 0; i < n; i++) begin
      ix = addr[17:0] + 18'(i);
      v[8*i +: 8] = mem_img[ix];
    end
    return v;
  endfunction

  function automatic void put_bytes(bit [63:0] addr, bit [63:0] data, int n);
    bit [17:0] ix;
    for (int i = 0; i < n; i++) begin
      ix = addr[17:0] + 18'(i);
      mem_img[ix] = data[8*i +: 8];
    end
  endfunction

  function automatic bit [63:0] sx(bit [63:0] v, int bits);
    return 64'($signed(v << (64 - bits)) >>> (64 - bits));
  endfunction

  function automatic bit [63:0] sxw(bit [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic void divrem(bit [63:0] a, bit [63:0] b,
                                 output bit [63:0] q, output bit [63:0] r);
    bit [63:0] ua, ub;
    if (b == 0) begin
      q = '1;
      r = a;
    end else begin
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (a[63] != b[63]) q = -q;
      if (a[63]) r = -r;
    end
  endfunction

  function automatic out_item_t step_core(in_item_t it);
    out_item_t o;
    bit [63:0] pc, nxt, a, b, imm_i, t, val, q, r, ua, ub;
    bit [31:0] inst;
    bit [4:0]  rd;
    bit [2:0]  f3;
    bit [6:0]  f7;
    bit [5:0]  f6;
    bit [5:0]  sh6;
    bit [4:0]  sh5;
    bit        wr, bad, take;
    o = '0;
    if (it.req_type == ReqPreload) begin
      put_bytes({46'd0, it.load_word_index, 2'b00}, {32'd0, it.load_word_data}, 4);
    end else if (!halt_q) begin
      pc    = {46'd0, pc_q};
      inst  = get_bytes(pc, 4);
      nxt   = pc + 4;
      val   = '0;
      wr    = 1'b0;
      bad   = 1'b0;
      take  = 1'b0;
      rd    = inst[11:7];
      f3    = inst[14:12];
      f7    = inst[31:25];
      f6    = inst[31:26];
      sh6   = inst[25:20];
      sh5   = inst[24:20];
      a     = xreg[inst[19:15]];
      b     = xreg[inst[24:20]];
      ua    = {32'd0, a[31:0]};
      ub    = {32'd0, b[31:0]};
      imm_i = {{52{inst[31]}}, inst[31:20]};
      if (inst[1:0] != 2'b11) bad = 1'b1;
      else begin
        case (inst[6:0])
          OpLui: begin
            val = {{32{inst[31]}}, inst[31:12], 12'd0};
            wr  = 1'b1;
          end
          OpAuipc: begin
            val = pc + {{32{inst[31]}}, inst[31:12], 12'd0};
            wr  = 1'b1;
          end
          OpJal: begin
            t   = {{44{inst[31]}}, inst[19:12], inst[20], inst[30:21], 1'b0};
            val = pc + 4;
            wr  = 1'b1;
            nxt = pc + t;
          end
          OpJalr: begin
            if (f3 != 0) bad = 1'b1;
            else begin
              nxt = (a + imm_i) & ~64'd1;
              val = pc + 4;
              wr  = 1'b1;
            end
          end
          OpBranch: begin
            t = {{52{inst[31]}}, inst[7], inst[30:25], inst[11:8], 1'b0};
            case (f3)
              F3Beq:   take = (a == b);
              F3Bne:   take = (a != b);
              F3Blt:   take = ($signed(a) < $signed(b));
              F3Bge:   take = ($signed(a) >= $signed(b));
              default: bad = 1'b1;
            endcase
            if (take) nxt = pc + t;
          end
          OpLoad: begin
            t  = a + imm_i;
            wr = 1'b1;
            case (f3)
              F3Lb:    val = sx(get_bytes(t, 1), 8);
              F3Lh:    val = sx(get_bytes(t, 2), 16);
              F3Lw:    val = sxw(get_bytes(t, 4));
              F3Ld:    val = get_bytes(t, 8);
              F3Lbu:   val = get_bytes(t, 1);
              F3Lhu:   val = get_bytes(t, 2);
              F3Lwu:   val = get_bytes(t, 4);
              default: bad = 1'b1;
            endcase
          end
          OpStore: begin
            if (f3 > F3Sd) bad = 1'b1;
            else begin
              t = a + {{52{inst[31]}}, inst[31:25], inst[11:7]};
              put_bytes(t, b, 1 << f3);
            end
          end
          OpImm: begin
            wr = 1'b1;
            case (f3)
              F3Add: val = a + imm_i;
              F3Xor: val = a ^ imm_i;
              F3Or:  val = a | imm_i;
              F3And: val = a & imm_i;
              F3Sll: if (f6 == 0) val = a << sh6; else bad = 1'b1;
              F3Srl: begin
                if (f6 == 0) val = a >> sh6;
                else if (f6 == F6Sra) val = 64'($signed(a) >>> sh6);
                else bad = 1'b1;
              end
              default: bad = 1'b1;
            endcase
          end
          OpImmW: begin
            wr = 1'b1;
            if (f3 == F3Add) val = sxw(a + imm_i);
            else if (f3 == F3Sll && f7 == F7Zero) val = sxw(a << sh5);
            else if (f3 == F3Srl && f7 == F7Zero) val = sxw(ua >> sh5);
            else if (f3 == F3Srl && f7 == F7Alt) val = sxw(64'($signed(sxw(a)) >>> sh5));
            else bad = 1'b1;
          end
          OpReg: begin
            wr = 1'b1;
            if (f7 == F7Zero) begin
              case (f3)
                F3Add:   val = a + b;
                F3Sll:   val = a << b[5:0];
                F3Xor:   val = a ^ b;
                F3Srl:   val = a >> b[5:0];
                F3Or:    val = a | b;
                F3And:   val = a & b;
                default: bad = 1'b1;
              endcase
            end else if (f7 == F7Alt && f3 == F3Add) val = a - b;
            else if (f7 == F7Alt && f3 == F3Srl) val = 64'($signed(a) >>> b[5:0]);
            else if (f7 == F7Mul && f3 == F3Mul) val = a * b;
            else if (f7 == F7Mul && f3 == F3Div) begin divrem(a, b, q, r); val = q; end
            else if (f7 == F7Mul && f3 == F3Rem) begin divrem(a, b, q, r); val = r; end
            else bad = 1'b1;
          end
          OpRegW: begin
            wr = 1'b1;
            if (f7 == F7Zero && f3 == F3Add) val = sxw(a + b);
            else if (f7 == F7Alt && f3 == F3Add) val = sxw(a - b);
            else if (f7 == F7Mul && f3 == F3Mul) val = sxw(a * b);
            else if (f7 == F7Zero && f3 == F3Sll) val = sxw(a << b[4:0]);
            else if (f7 == F7Zero && f3 == F3Srl) val = sxw(ua >> b[4:0]);
            else if (f7 == F7Alt && f3 == F3Srl) val = sxw(64'($signed(sxw(a)) >>> b[4:0]));
            else if (f7 == F7Mul && (f3 == F3Div || f3 == F3Rem)) begin
              divrem(sxw(a), sxw(b), q, r);
              val = sxw(f3 == F3Div ? q : r);
            end else if (f7 == F7Mul && (f3 == F3Divu || f3 == F3Remu)) begin
              if (ub == 0) begin
                q = 64'hffff_ffff;
                r = ua;
              end else begin
                q = ua / ub;
                r = ua % ub;
              end
              val = sxw(f3 == F3Divu ? q : r);
            end else bad = 1'b1;
          end
          OpSystem: begin
            if (inst != InstEcall) bad = 1'b1;
            else begin
              t = xreg[RegA7];
              if (t == EcallExit) halt_q = 1'b1;
              else if (t == EcallGetc) begin
                rd = RegA0;
                val = {56'd0, it.console_in};
                wr = 1'b1;
                o.console_in_taken = 1'b1;
              end else if (t == EcallPutc) begin
                o.console_out_valid = 1'b1;
                o.console_out = xreg[RegA0][7:0];
              end
            end
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        wr = 1'b0;
        nxt = pc + 4;
        o.illegal = 1'b1;
      end
      if (wr && rd != 0) begin
        xreg[rd]     = val;
        o.rd_written = 1'b1;
        o.rd_index   = rd;
        o.rd_value   = val;
      end
      pc_q = nxt[PcW-1:0];
    end
    o.pc_after = pc_q;
    o.halted   = halt_q;
    return o;
  endfunction

  function automatic void cmp(string nm, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      if (errors < 10)
        $display("mismatch %s: expected %h, got %h", nm, e, g);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) xreg[i] = '0;
      xreg[RegSp] = 64'(MemBytesDefault);
      pc_q = '0;
      halt_q = 1'b0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) result_q.push_back(step_core(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected transaction on result side: %p", out_data);
          errors++;
        end else begin
          e = result_q.pop_front();
          cmp("pc_after", e.pc_after, out_data.pc_after);
          cmp("rd_written", e.rd_written, out_data.rd_written);
          cmp("rd_index", e.rd_index, out_data.rd_index);
          cmp("rd_value", e.rd_value, out_data.rd_value);
          cmp("console_out_valid", e.console_out_valid, out_data.console_out_valid);
          cmp("console_out", e.console_out, out_data.console_out);
          cmp("console_in_taken", e.console_in_taken, out_data.console_in_taken);
          cmp("halted", e.halted, out_data.halted);
          cmp("illegal", e.illegal, out_data.illegal);
        end
      end
    end
    fail_count <= errors;
    pending    <= result_q.size();
  end

  initial errors = 0;

endmodule

>>> dv/tb_rv64_instruction_step_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rv64_instruction_step_top
// runs short programs on the rv64 step core and checks every result
// ---------------------------------------------------------------------------
// The code word at the current pc is preloaded right before each execute
// transaction, and loads and stores only use x0 as base inside a small data
// window that is preloaded first, so nothing ever reads unwritten memory.
module tb_rv64_instruction_step_top;
  import rv64s_pkg::*;
  import rv64s_tb_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  in_item_t     in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  out_item_t    out_data;
  int unsigned  fail_count;
  int unsigned  pending;

  int unsigned  issued = 0;
  int unsigned  done_cnt = 0;
  logic [17:0]  last_pc = '0;
  bit           quiet = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  idle_cycles = 0;

  rv64_instruction_step_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rv64_step_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      done_cnt <= 0;
    end else if (out_valid && !out_stall) begin
      done_cnt <= done_cnt + 1;
      last_pc  <= out_data.pc_after;
    end
  end

  // result side backpressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBranch};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OpJal};
  endfunction

  function automatic logic [4:0] rreg();
    return 5'($urandom_range(0, 31));
  endfunction

  // data window offset from x0: -16 .. 8, so accesses stay in bytes -16 .. 15 after wrapping
  function automatic logic [11:0] data_off();
    return 12'($urandom_range(0, 24) - 16);
  endfunction

  function automatic logic [31:0] rand_inst();
    logic [31:0] w;
    logic [2:0]  f3;
    int          k;
    k = $urandom_range(0, 99);
    if (k < 10) return {20'($urandom), rreg(), OpLui};
    if (k < 14) return {20'($urandom), rreg(), OpAuipc};
    if (k < 18) return enc_j({20'($urandom), 1'b0}, rreg());
    if (k < 21) return enc_i(12'($urandom), rreg(), F3Add, rreg(), OpJalr);
    if (k < 29) begin
      case ($urandom_range(0, 3))
        0: f3 = F3Beq;
        1: f3 = F3Bne;
        2: f3 = F3Blt;
        default: f3 = F3Bge;
      endcase
      return enc_b({12'($urandom), 1'b0}, rreg(), rreg(), f3);
    end
    if (k < 39) return enc_i(data_off(), 5'd0, 3'($urandom_range(0, 6)), rreg(), OpLoad);
    if (k < 46) return enc_s(data_off(), rreg(), 5'd0, 3'($urandom_range(0, 3)));
    if (k < 61) begin
      w = enc_i(12'($urandom), rreg(), 3'($urandom), rreg(), OpImm);
      if (w[14:12] == F3Sll && $urandom_range(0, 7) != 0) w[31:26] = '0;
      if (w[14:12] == F3Srl && $urandom_range(0, 7) != 0)
        w[31:26] = $urandom_range(0, 1) ? F6Sra : 6'd0;
      return w;
    end
    if (k < 67) begin
      case ($urandom_range(0, 4))
        0: return enc_i(12'($urandom), rreg(), F3Add, rreg(), OpImmW);
        1: return enc_r(F7Zero, rreg(), rreg(), F3Sll, rreg(), OpImmW);
        2: return enc_r(F7Zero, rreg(), rreg(), F3Srl, rreg(), OpImmW);
        3: return enc_r(F7Alt, rreg(), rreg(), F3Srl, rreg(), OpImmW);
        default: return enc_i(12'($urandom), rreg(), 3'($urandom), rreg(), OpImmW);
      endcase
    end
    if (k < 83) begin
      case ($urandom_range(0, 12))
        0: return enc_r(F7Zero, rreg(), rreg(), F3Add, rreg(), OpReg);
        1: return enc_r(F7Zero, rreg(), rreg(), F3Sll, rreg(), OpReg);
        2: return enc_r(F7Zero, rreg(), rreg(), F3Xor, rreg(), OpReg);
        3: return enc_r(F7Zero, rreg(), rreg(), F3Srl, rreg(), OpReg);
        4: return enc_r(F7Zero, rreg(), rreg(), F3Or, rreg(), OpReg);
        5: return enc_r(F7Zero, rreg(), rreg(), F3And, rreg(), OpReg);
        6: return enc_r(F7Alt, rreg(), rreg(), F3Add, rreg(), OpReg);
        7: return enc_r(F7Alt, rreg(), rreg(), F3Srl, rreg(), OpReg);
        8: return enc_r(F7Mul, rreg(), rreg(), F3Mul, rreg(), OpReg);
        9: return enc_r(F7Mul, rreg(), rreg(), F3Div, rreg(), OpReg);
        10: return enc_r(F7Mul, rreg(), rreg(), F3Rem, rreg(), OpReg);
        default: return enc_r(7'($urandom), rreg(), rreg(), 3'($urandom), rreg(), OpReg);
      endcase
    end
    if (k < 91) begin
      case ($urandom_range(0, 10))
        0: return enc_r(F7Zero, rreg(), rreg(), F3Add, rreg(), OpRegW);
        1: return enc_r(F7Alt, rreg(), rreg(), F3Add, rreg(), OpRegW);
        2: return enc_r(F7Mul, rreg(), rreg(), F3Mul, rreg(), OpRegW);
        3: return enc_r(F7Zero, rreg(), rreg(), F3Sll, rreg(), OpRegW);
        4: return enc_r(F7Zero, rreg(), rreg(), F3Srl, rreg(), OpRegW);
        5: return enc_r(F7Alt, rreg(), rreg(), F3Srl, rreg(), OpRegW);
        6: return enc_r(F7Mul, rreg(), rreg(), F3Div, rreg(), OpRegW);
        7: return enc_r(F7Mul, rreg(), rreg(), F3Divu, rreg(), OpRegW);
        8: return enc_r(F7Mul, rreg(), rreg(), F3Rem, rreg(), OpRegW);
        9: return enc_r(F7Mul, rreg(), rreg(), F3Remu, rreg(), OpRegW);
        default: return enc_r(7'($urandom), rreg(), rreg(), 3'($urandom), rreg(), OpRegW);
      endcase
    end
    // noise, half of it on a listed opcode to reach unlisted funct codes
    w = $urandom;
    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 5))
        0: w[6:0] = OpBranch;
        1: w[6:0] = OpImm;
        2: w[6:0] = OpReg;
        3: w[6:0] = OpRegW;
        4: w[6:0] = OpSystem;
        default: w[6:0] = OpJalr;
      endcase
    end
    // a random base would load from unwritten memory
    if (w[6:0] == OpLoad || w[6:0] == OpJalr && w[14:12] == F3Add) w[2] = 1'b1;
    return w;
  endfunction

  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    issued++;
  endtask

  task automatic send_preload(logic [15:0] idx, logic [31:0] data);
    in_item_t it;
    it = '{req_type: ReqPreload, load_word_index: idx, load_word_data: data,
           console_in: 8'($urandom)};
    send(it);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (done_cnt != issued);
  endtask

  task automatic run_inst(logic [31:0] inst);
    logic [63:0] pair;
    int          off;
    in_item_t    it;
    drain();
    off  = last_pc[1:0];
    pair = {$urandom, $urandom};
    pair[8*off +: 32] = inst;
    send_preload(last_pc[17:2], pair[31:0]);
    if (off != 0) send_preload(last_pc[17:2] + 16'd1, pair[63:32]);
    it = '{req_type: ReqExec, load_word_index: 16'($urandom),
           load_word_data: $urandom, console_in: 8'($urandom)};
    send(it);
  endtask

  task automatic run_ecall(logic [11:0] code);
    run_inst(enc_i(code, 5'd0, F3Add, RegA7, OpImm));
    run_inst(InstEcall);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // data window around address zero, with all-ones and all-zeros words
    send_preload(16'hffff, 32'hffff_ffff);
    send_preload(16'h0000, 32'h0000_0000);
    for (int i = 1; i < 4; i++) send_preload(16'(i), $urandom);
    for (int i = 2; i < 5; i++) send_preload(16'(-i), $urandom);

    run_inst(enc_i(12'd1, 5'd0, F3Add, 5'd6, OpImm));
    run_inst(enc_i(12'd63, 5'd6, F3Sll, 5'd6, OpImm));
    run_inst(enc_i(12'hfff, 5'd0, F3Add, 5'd7, OpImm));
    // signed overflow and divide by zero
    run_inst(enc_r(F7Mul, 5'd7, 5'd6, F3Div, 5'd8, OpReg));
    run_inst(enc_r(F7Mul, 5'd7, 5'd6, F3Rem, 5'd9, OpReg));
    run_inst(enc_r(F7Mul, 5'd0, 5'd6, F3Div, 5'd10, OpReg));
    run_inst(enc_r(F7Mul, 5'd0, 5'd6, F3Rem, 5'd11, OpReg));
    run_inst({20'h80000, 5'd5, OpLui});
    run_inst(enc_r(F7Mul, 5'd7, 5'd5, F3Div, 5'd12, OpRegW));
    run_inst(enc_r(F7Mul, 5'd0, 5'd5, F3Divu, 5'd13, OpRegW));
    run_inst(enc_r(F7Mul, 5'd0, 5'd5, F3Remu, 5'd14, OpRegW));
    run_inst(enc_i(12'hff0, 5'd0, F3Ld, 5'd15, OpLoad));
    run_inst(enc_s(12'hff8, 5'd7, 5'd0, F3Sd));
    // write to x0 is dropped
    run_inst(enc_i(12'd5, 5'd7, F3Add, 5'd0, OpImm));
    run_inst(32'h0000_0000);
    run_ecall(12'(EcallGetc));
    run_ecall(12'(EcallPutc));
    run_ecall(12'd3);
    // odd target gets bit 0 cleared, fetch then straddles two words
    run_inst(enc_i(12'd0, 5'd7, F3Add, 5'd1, OpJalr));

    n = issued + 400;
    while (issued < n) begin
      if (issued + 60 >= n) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0: send_preload(16'($urandom), $urandom);
        1: run_ecall(12'($urandom_range(1, 4)));
        default: run_inst(rand_inst());
      endcase
    end

    run_ecall(12'(EcallExit));
    run_inst(rand_inst());
    send_preload(16'($urandom), $urandom);
    run_inst(InstEcall);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
